FILE: sv/alu16_pkg.sv
// ----------------------------------------------------------------------------
// alu16_pkg
// Shared types and constants for the 16-bit arithmetic, logic and shift ALU.
// ----------------------------------------------------------------------------
package alu16_pkg;

  localparam int unsigned WordWidth = 16;
  localparam int unsigned FuncWidth = 4;

  typedef logic [WordWidth-1:0] word_t;

  typedef enum logic [FuncWidth-1:0] {
    FuncAdd  = 4'd0,
    FuncSub  = 4'd1,
    FuncAdc  = 4'd2,
    FuncSbc  = 4'd3,
    FuncXor  = 4'd4,
    FuncAnd  = 4'd5,
    FuncOr   = 4'd6,
    FuncNot  = 4'd7,
    FuncNeg  = 4'd8,
    FuncAsl  = 4'd9,
    FuncAsr  = 4'd10,
    FuncRol  = 4'd11,
    FuncRor  = 4'd12,
    FuncPass = 4'd13
  } func_e;

  typedef struct packed {
    logic [FuncWidth-1:0] func;
    word_t                operand_a;
    word_t                operand_b;
    logic                 carry_in;
  } req_t;

  typedef struct packed {
    word_t result;
    logic  carry_out;
  } res_t;

endpackage

FILE: sv/alu16_eval.sv
// ----------------------------------------------------------------------------
// alu16_eval
// Combinational evaluation of one ALU request: result word and carry-out.
// ----------------------------------------------------------------------------
module alu16_eval (
  input  alu16_pkg::req_t req_i,
  output alu16_pkg::res_t res_o
);

  alu16_pkg::word_t a;
  alu16_pkg::word_t b;
  logic             cin;

  assign a   = req_i.operand_a;
  assign b   = req_i.operand_b;
  assign cin = req_i.carry_in;

  always_comb begin
    res_o.carry_out = cin;
    case (alu16_pkg::func_e'(req_i.func))
      alu16_pkg::FuncAdd: res_o.result = a + b;
      alu16_pkg::FuncSub: res_o.result = a + ~b + 16'd1;
      alu16_pkg::FuncAdc: res_o.result = a + b + {15'd0, cin};
      alu16_pkg::FuncSbc: res_o.result = a + ~b + {15'd0, cin};
      alu16_pkg::FuncXor: res_o.result = a ^ b;
      alu16_pkg::FuncAnd: res_o.result = a & b;
      alu16_pkg::FuncOr:  res_o.result = a | b;
      alu16_pkg::FuncNot: res_o.result = ~a;
      alu16_pkg::FuncNeg: res_o.result = ~a + 16'd1;
      alu16_pkg::FuncAsl: res_o.result = {a[14:0], 1'b0};
      alu16_pkg::FuncAsr: res_o.result = {a[15], a[15:1]};
      alu16_pkg::FuncRol: begin
        res_o.result    = {a[14:0], cin};
        res_o.carry_out = a[15];
      end
      alu16_pkg::FuncRor: begin
        res_o.result    = {cin, a[15:1]};
        res_o.carry_out = a[0];
      end
      default: res_o.result = a;
    endcase
  end

endmodule

FILE: sv/alu16_arith_logic_shift.sv
// ----------------------------------------------------------------------------
// alu16_arith_logic_shift
// 16-bit ALU with add, subtract, logic, shift and rotate-through-carry.
// ----------------------------------------------------------------------------
// An accepted request passes through the input register and then the result register to its done_o strobe.
// Throughput is one request per cycle, set by the input and result registers.
// The block is never busy, and the receiver cannot stall it.
// Reset clears the valid bits of both stages; payload registers are not reset.
module alu16_arith_logic_shift (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [alu16_pkg::FuncWidth-1:0] func_i,
  input  logic [alu16_pkg::WordWidth-1:0] operand_a_i,
  input  logic [alu16_pkg::WordWidth-1:0] operand_b_i,
  input  logic                            carry_in_i,
  output logic                            done_o,
  output logic [alu16_pkg::WordWidth-1:0] result_o,
  output logic                            carry_out_o
);

  logic            req_valid_q;
  alu16_pkg::req_t req_q;
  alu16_pkg::req_t req_d;
  alu16_pkg::res_t res_d;
  alu16_pkg::res_t res_q;
  logic            done_q;

  assign busy_o = 1'b0;

  assign req_d = '{func: func_i, operand_a: operand_a_i,
                   operand_b: operand_b_i, carry_in: carry_in_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      req_valid_q <= start_i && !busy_o;
      done_q      <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      req_q <= req_d;
    end
    if (req_valid_q) begin
      res_q <= res_d;
    end
  end

  alu16_eval u_eval (
    .req_i (req_q),
    .res_o (res_d)
  );

  assign done_o      = done_q;
  assign result_o    = res_q.result;
  assign carry_out_o = res_q.carry_out;

  a_done_follows_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_q |=> done_o)
    else $error("Request in the input stage did not produce a result.");

  a_done_has_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(req_valid_q))
    else $error("Result strobe without a request in the input stage.");

  a_carry_passes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_q && req_q.func != alu16_pkg::FuncRol
                 && req_q.func != alu16_pkg::FuncRor)
    |=> (carry_out_o == $past(req_q.carry_in)))
    else $error("Carry-out differs from carry-in for a non-rotate request.");

endmodule

FILE: test/alu16_checker.sv
// ----------------------------------------------------------------------------
// alu16_checker
// Watches the request and result ports of the 16-bit ALU. For every accepted
// request it computes the expected result word and carry-out and queues them.
// Each result strobe is compared field by field with the oldest expected
// result. It reports the number of mismatches and outstanding results.
// ----------------------------------------------------------------------------
module alu16_checker
  import alu16_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  logic [FuncWidth-1:0] func_i,
  input  word_t                operand_a_i,
  input  word_t                operand_b_i,
  input  logic                 carry_in_i,
  input  logic                 done_i,
  input  word_t                result_i,
  input  logic                 carry_out_i,
  output int unsigned          outstanding_o,
  output int unsigned          mismatch_count_o
);

  res_t expected_results[$];

  function automatic res_t alu_compute(logic [FuncWidth-1:0] func, word_t a, word_t b,
                                       logic cin);
    res_t r;
    r.carry_out = cin;
    case (func)
      FuncAdd:  r.result = a + b;
      FuncSub:  r.result = a + ~b + 1'b1;
      FuncAdc:  r.result = a + b + cin;
      FuncSbc:  r.result = a + ~b + cin;
      FuncXor:  r.result = a ^ b;
      FuncAnd:  r.result = a & b;
      FuncOr:   r.result = a | b;
      FuncNot:  r.result = ~a;
      FuncNeg:  r.result = ~a + 1'b1;
      FuncAsl:  r.result = {a[WordWidth-2:0], 1'b0};
      FuncAsr:  r.result = {a[WordWidth-1], a[WordWidth-1:1]};
      FuncRol: begin
        r.result    = {a[WordWidth-2:0], cin};
        r.carry_out = a[WordWidth-1];
      end
      FuncRor: begin
        r.result    = {cin, a[WordWidth-1:1]};
        r.carry_out = a[0];
      end
      // Pass and the two unused codes all forward operand a.
      default:  r.result = a;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      expected_results.delete();
      mismatch_count_o = 0;
    end else begin
      if (start_i && !busy_i) begin
        expected_results.push_back(alu_compute(func_i, operand_a_i, operand_b_i, carry_in_i));
      end
      if (done_i) begin
        if (expected_results.size() == 0) begin
          $error("Result strobe with no request outstanding: result %h, carry_out %b",
                 result_i, carry_out_i);
          mismatch_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (result_i !== want.result) begin
            $error("result: expected %h, actual %h", want.result, result_i);
            mismatch_count_o++;
          end
          if (carry_out_i !== want.carry_out) begin
            $error("carry_out: expected %b, actual %b", want.carry_out, carry_out_i);
            mismatch_count_o++;
          end
        end
      end
    end
    outstanding_o = expected_results.size();
  end

endmodule

FILE: test/tb_alu16_arith_logic_shift.sv
// ----------------------------------------------------------------------------
// tb_alu16_arith_logic_shift
// Drives directed corner requests for every operation code, then random
// requests with random gaps and gap-free bursts, into the 16-bit ALU. A
// separate checker predicts and compares every result; this module gives
// the verdict once all results have arrived.
// ----------------------------------------------------------------------------
module tb_alu16_arith_logic_shift;
  import alu16_pkg::*;

  localparam int unsigned HalfPeriod = 5;
  localparam int unsigned ResetCycles = 8;
  localparam int unsigned NumRandom = 800;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned TimeLimit = 2_000_000;

  // The two codes beyond pass are unused and must behave as pass.
  localparam logic [FuncWidth-1:0] FuncUnusedLo = 4'd14;
  localparam logic [FuncWidth-1:0] FuncUnusedHi = 4'd15;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  logic [FuncWidth-1:0] func_i;
  word_t                operand_a_i;
  word_t                operand_b_i;
  logic                 carry_in_i;
  logic                 done_o;
  word_t                result_o;
  logic                 carry_out_o;
  int unsigned          outstanding;
  int unsigned          mismatches;
  bit                   bursting;

  always #HalfPeriod clk_i = ~clk_i;

  alu16_arith_logic_shift dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .func_i      (func_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .carry_in_i  (carry_in_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .carry_out_o (carry_out_o)
  );

  alu16_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_i           (busy_o),
    .func_i           (func_i),
    .operand_a_i      (operand_a_i),
    .operand_b_i      (operand_b_i),
    .carry_in_i       (carry_in_i),
    .done_i           (done_o),
    .result_i         (result_o),
    .carry_out_i      (carry_out_o),
    .outstanding_o    (outstanding),
    .mismatch_count_o (mismatches)
  );

  function automatic word_t pick_operand();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      4:       return 16'h0001;
      default: return word_t'($urandom());
    endcase
  endfunction

  // Holds one request until it is taken, then idles for a random gap, which may be empty.
  task automatic send_request(logic [FuncWidth-1:0] func, word_t a, word_t b, logic cin);
    bit free;
    int unsigned idle;
    int unsigned roll;
    start_i     <= 1'b1;
    func_i      <= func;
    operand_a_i <= a;
    operand_b_i <= b;
    carry_in_i  <= cin;
    forever begin
      @(negedge clk_i);
      free = !busy_o;
      @(posedge clk_i);
      if (free) break;
    end
    roll = $urandom_range(0, 99);
    if (bursting || roll < 55) idle = 0;
    else if (roll < 92) idle = $urandom_range(1, 3);
    else idle = $urandom_range(8, 40);
    if (idle > 0) begin
      start_i     <= 1'b0;
      func_i      <= func_i ^ FuncWidth'($urandom());
      operand_a_i <= word_t'($urandom());
      operand_b_i <= word_t'($urandom());
      carry_in_i  <= 1'($urandom());
      repeat (idle) @(posedge clk_i);
    end
  endtask

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    func_i      = '0;
    operand_a_i = '0;
    operand_b_i = '0;
    carry_in_i  = 1'b0;
    bursting    = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(FuncAdd,      16'hFFFF, 16'h0001, 1'b0);
    send_request(FuncAdd,      16'h0000, 16'h0000, 1'b1);
    send_request(FuncSub,      16'h0000, 16'h0001, 1'b0);
    send_request(FuncSub,      16'h8000, 16'h7FFF, 1'b1);
    send_request(FuncAdc,      16'hFFFF, 16'h0000, 1'b1);
    send_request(FuncAdc,      16'h7FFF, 16'h7FFF, 1'b1);
    send_request(FuncSbc,      16'h0000, 16'h0000, 1'b0);
    send_request(FuncSbc,      16'h1234, 16'h1234, 1'b1);
    send_request(FuncXor,      16'hFFFF, 16'h5555, 1'b0);
    send_request(FuncAnd,      16'hAAAA, 16'hFFFF, 1'b1);
    send_request(FuncOr,       16'h0000, 16'h8001, 1'b0);
    send_request(FuncNot,      16'h0000, 16'hFFFF, 1'b1);
    send_request(FuncNeg,      16'h0000, 16'h1234, 1'b0);
    send_request(FuncNeg,      16'h8000, 16'h0000, 1'b1);
    send_request(FuncAsl,      16'h8001, 16'h0000, 1'b1);
    send_request(FuncAsr,      16'h8000, 16'h0000, 1'b0);
    send_request(FuncAsr,      16'h7FFF, 16'hFFFF, 1'b1);
    send_request(FuncRol,      16'h8000, 16'h0000, 1'b0);
    send_request(FuncRol,      16'h7FFF, 16'h0000, 1'b1);
    send_request(FuncRor,      16'h0001, 16'h0000, 1'b0);
    send_request(FuncRor,      16'hFFFE, 16'h0000, 1'b1);
    send_request(FuncPass,     16'hFFFF, 16'h0000, 1'b1);
    send_request(FuncUnusedLo, 16'h1234, 16'hFFFF, 1'b0);
    send_request(FuncUnusedHi, 16'hABCD, 16'h5555, 1'b1);

    for (int i = 0; i < NumRandom; i++) begin
      if (i % 64 == 0) bursting = ($urandom_range(0, 2) == 0);
      send_request(FuncWidth'($urandom_range(0, (1 << FuncWidth) - 1)),
                   pick_operand(), pick_operand(), 1'($urandom()));
    end
    start_i <= 1'b0;

    do @(negedge clk_i); while (outstanding != 0);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #TimeLimit;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: filelist.f
sv/alu16_pkg.sv
sv/alu16_eval.sv
sv/alu16_arith_logic_shift.sv
test/alu16_checker.sv
test/tb_alu16_arith_logic_shift.sv
